// File: rtl/mcst_pkg.sv
package mcst_pkg;

  // number of timer slots sharing the tick
  localparam int unsigned NUM_TIMERS = 16;
  localparam int unsigned IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned MASK_W  = 16;

  // command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STOP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd3;

  // classified operation carried to the back part
  typedef enum logic [2:0] {
    OP_CREATE,
    OP_STOP,
    OP_DELETE,
    OP_TICK,
    OP_NONE
  } op_t;

  // one queued word
  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   idx;
    logic [COUNT_W-1:0] duration;
    logic               periodic;
  } q_entry_t;

  // map a slot vector onto a fixed-width mask, slots past the mask are dropped
  function automatic logic [MASK_W-1:0] to_mask(input logic [NUM_TIMERS-1:0] v);
    logic [NUM_TIMERS+MASK_W-1:0] ext;
    ext = {{MASK_W{1'b0}}, v};
    return ext[MASK_W-1:0];
  endfunction

endpackage

// File: rtl/mcst_front.sv
module mcst_front
  import mcst_pkg::*;
(
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [COUNT_W-1:0] in_duration,
  input  logic               in_periodic,
  output logic               push_valid,
  input  logic               push_ready,
  output q_entry_t           push_entry
);

  logic slot_ok;

  // slots at or beyond the table size are ignored
  assign slot_ok = (32'(in_slot) < NUM_TIMERS);

  // classify the command
  always_comb begin
    push_entry.idx      = IDX_W'(in_slot);
    push_entry.duration = in_duration;
    push_entry.periodic = in_periodic;
    push_entry.op       = OP_NONE;
    unique case (in_cmd)
      CMD_TICK:   push_entry.op = OP_TICK;
      CMD_CREATE: push_entry.op = slot_ok ? OP_CREATE : OP_NONE;
      CMD_STOP:   push_entry.op = slot_ok ? OP_STOP   : OP_NONE;
      CMD_DELETE: push_entry.op = slot_ok ? OP_DELETE : OP_NONE;
      default:    push_entry.op = OP_NONE;
    endcase
  end

  // handshake into the queue
  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

// File: rtl/mcst_queue.sv
module mcst_queue
  import mcst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  q_entry_t push_entry,
  output logic     pop_valid,
  input  logic     pop_ready,
  output q_entry_t pop_entry
);

  q_entry_t   store_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = store_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// File: rtl/mcst_back.sv
module mcst_back
  import mcst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  q_entry_t          pop_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MASK_W-1:0] out_fired,
  output logic [MASK_W-1:0] out_active,
  output logic [MASK_W-1:0] out_alloc
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t                 state_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic [IDX_W-1:0]       proc_idx_r;
  logic                   proc_v_r;
  logic [COUNT_W-1:0]     cnt_rd_r;
  logic [COUNT_W-1:0]     rel_rd_r;
  logic [NUM_TIMERS-1:0]  active_r;
  logic [NUM_TIMERS-1:0]  periodic_r;
  logic [NUM_TIMERS-1:0]  alloc_r;
  logic [NUM_TIMERS-1:0]  fired_r;
  logic                   out_valid_r;
  logic [MASK_W-1:0]      out_fired_r;
  logic [MASK_W-1:0]      out_active_r;
  logic [MASK_W-1:0]      out_alloc_r;

  logic [COUNT_W-1:0]     cnt_mem [NUM_TIMERS];
  logic [COUNT_W-1:0]     rel_mem [NUM_TIMERS];

  logic                   pop;
  logic                   proc_act;
  logic [COUNT_W-1:0]     cnt_dec;
  logic                   expire;
  logic                   cnt_we;
  logic [IDX_W-1:0]       cnt_waddr;
  logic [COUNT_W-1:0]     cnt_wdata;
  logic                   rel_we;

  assign pop_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign pop        = pop_valid && pop_ready;
  assign out_valid  = out_valid_r;
  assign out_fired  = out_fired_r;
  assign out_active = out_active_r;
  assign out_alloc  = out_alloc_r;

  // countdown step for the slot read on the previous cycle
  assign proc_act = proc_v_r && active_r[proc_idx_r];
  assign cnt_dec  = (cnt_rd_r != '0) ? (cnt_rd_r - COUNT_W'(1)) : '0;
  assign expire   = proc_act && (cnt_dec == '0);

  // write port select: create load or sweep write-back
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = pop_entry.idx;
    cnt_wdata = pop_entry.duration;
    rel_we    = pop && (pop_entry.op == OP_CREATE);
    if (rel_we) begin
      cnt_we = 1'b1;
    end else if (proc_act) begin
      cnt_we    = 1'b1;
      cnt_waddr = proc_idx_r;
      cnt_wdata = (cnt_dec == '0) ? rel_rd_r : cnt_dec;
    end
  end

  // count and reload storage
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (rel_we) begin
      rel_mem[pop_entry.idx] <= pop_entry.duration;
    end
    cnt_rd_r <= cnt_mem[rd_idx_r];
    rel_rd_r <= rel_mem[rd_idx_r];
  end

  // sequencer, slot flags and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_idx_r    <= '0;
      proc_idx_r  <= '0;
      proc_v_r    <= 1'b0;
      active_r    <= '0;
      periodic_r  <= '0;
      alloc_r     <= '0;
      fired_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      proc_v_r   <= (state_r == S_SWEEP);
      proc_idx_r <= rd_idx_r;

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      // expiry marks the slot fired; a one-shot expiry also frees the slot
      if (expire) begin
        fired_r[proc_idx_r] <= 1'b1;
        if (!periodic_r[proc_idx_r]) begin
          active_r[proc_idx_r]   <= 1'b0;
          alloc_r[proc_idx_r]    <= 1'b0;
          periodic_r[proc_idx_r] <= 1'b0;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            fired_r  <= '0;
            rd_idx_r <= '0;
            unique case (pop_entry.op)
              OP_CREATE: begin
                active_r[pop_entry.idx]   <= 1'b1;
                alloc_r[pop_entry.idx]    <= 1'b1;
                periodic_r[pop_entry.idx] <= pop_entry.periodic;
                state_r <= S_DONE;
              end
              OP_STOP: begin
                active_r[pop_entry.idx] <= 1'b0;
                state_r <= S_DONE;
              end
              OP_DELETE: begin
                active_r[pop_entry.idx]   <= 1'b0;
                alloc_r[pop_entry.idx]    <= 1'b0;
                periodic_r[pop_entry.idx] <= 1'b0;
                state_r <= S_DONE;
              end
              OP_TICK: state_r <= S_SWEEP;
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_SWEEP: begin
          if (rd_idx_r == IDX_W'(NUM_TIMERS - 1)) begin
            state_r <= S_DRAIN;
          end else begin
            rd_idx_r <= rd_idx_r + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid_r  <= 1'b1;
          out_fired_r  <= to_mask(fired_r);
          out_active_r <= to_mask(active_r);
          out_alloc_r  <= to_mask(alloc_r);
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/multi_channel_soft_timer_table.sv
// channel  | dir | tdata                                        | tuser
// in_      | in  | slot[3:0] duration[35:4] periodic[36] pad    | cmd[1:0]
// out_     | out | fired[15:0] active[31:16] allocated[47:32]   | -
//
// create, stop, delete and ignored commands are accepted and then load the
// result in the executor; a tick is accepted, reads one slot per cycle, does a
// last write-back and loads the result; one read and one write per cycle.
// the executor takes its next word only after the result word has left.
// a two-word queue lets the input side keep taking words while a result waits.
// reset clears all slot flags; counts and reload values are loaded by create.
module multi_channel_soft_timer_table
  import mcst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // slot, duration, periodic, zero pad
  input  logic [1:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // fired_mask, active_mask, allocated_mask
);

  logic     push_valid;
  logic     push_ready;
  q_entry_t push_entry;
  logic     pop_valid;
  logic     pop_ready;
  q_entry_t pop_entry;

  logic [MASK_W-1:0] fired;
  logic [MASK_W-1:0] active;
  logic [MASK_W-1:0] alloc;

  // decode incoming words
  mcst_front u_front (
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_cmd      (in_tuser),
    .in_slot     (in_tdata[3:0]),
    .in_duration (in_tdata[35:4]),
    .in_periodic (in_tdata[36]),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_entry  (push_entry)
  );

  // decoupling queue
  mcst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // slot table executor
  mcst_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_fired  (fired),
    .out_active (active),
    .out_alloc  (alloc)
  );

  assign out_tdata = {alloc, active, fired};

endmodule

// File: sim/tb_multi_channel_soft_timer_table.sv
`timescale 1ns / 100ps

module tb_multi_channel_soft_timer_table;
  import mcst_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned WORDS_PER_PHASE = 100;

  // result word as it sits on out_tdata, fired mask in the low bits
  typedef struct packed {
    logic [MASK_W-1:0] allocated;
    logic [MASK_W-1:0] active;
    logic [MASK_W-1:0] fired;
  } masks_t;

  // one command word plus an optional hand-written expectation
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] dur;
    logic               per;
    logic               has_exp;
    masks_t             exp;
  } cmd_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // slot, duration, periodic, zero pad
  logic [1:0]  in_tuser = '0;   // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // fired_mask, active_mask, allocated_mask

  // shadow copy of the timer table
  logic [COUNT_W-1:0]  shadow_left   [NUM_TIMERS];
  logic [COUNT_W-1:0]  shadow_reload [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] shadow_active    = '0;
  logic [NUM_TIMERS-1:0] shadow_periodic  = '0;
  logic [NUM_TIMERS-1:0] shadow_allocated = '0;

  masks_t    masks_due [$];
  cmd_word_t directed_words [$];

  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  bit          hold_req      = 1'b0;
  int unsigned mismatches    = 0;
  int unsigned expiries      = 0;
  int unsigned cmd_seen [4]  = '{0, 0, 0, 0};

  multi_channel_soft_timer_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // apply one command to the shadow table, return the masks it produces
  function automatic masks_t next_masks(logic [CMD_W-1:0] op, logic [SLOT_W-1:0] s,
                                        logic [COUNT_W-1:0] d, logic p);
    masks_t m;
    m = '0;
    if (op == CMD_TICK) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (shadow_active[i]) begin
          if (shadow_left[i] != '0) shadow_left[i] = shadow_left[i] - 1'b1;
          if (shadow_left[i] == '0) begin
            if (i < MASK_W) m.fired[i] = 1'b1;
            if (shadow_periodic[i]) begin
              shadow_left[i] = shadow_reload[i];
            end else begin
              shadow_active[i]    = 1'b0;
              shadow_allocated[i] = 1'b0;
              shadow_periodic[i]  = 1'b0;
            end
          end
        end
      end
    end else if (s < NUM_TIMERS) begin
      case (op)
        CMD_CREATE: begin
          shadow_reload[s]    = d;
          shadow_left[s]      = d;
          shadow_periodic[s]  = p;
          shadow_active[s]    = 1'b1;
          shadow_allocated[s] = 1'b1;
        end
        CMD_STOP: begin
          shadow_active[s] = 1'b0;
        end
        default: begin
          shadow_active[s]    = 1'b0;
          shadow_periodic[s]  = 1'b0;
          shadow_allocated[s] = 1'b0;
        end
      endcase
    end
    for (int i = 0; i < NUM_TIMERS && i < MASK_W; i++) begin
      m.active[i]    = shadow_active[i];
      m.allocated[i] = shadow_allocated[i];
    end
    return m;
  endfunction

  // random word: mostly ticks and creates with short durations
  function automatic cmd_word_t random_word();
    cmd_word_t w;
    int unsigned pick;
    w = '0;
    pick = $urandom_range(99);
    if (pick < 45)      w.cmd = CMD_TICK;
    else if (pick < 75) w.cmd = CMD_CREATE;
    else if (pick < 87) w.cmd = CMD_STOP;
    else                w.cmd = CMD_DELETE;
    w.slot = SLOT_W'($urandom_range(NUM_TIMERS - 1));
    pick = $urandom_range(99);
    if (pick < 70)      w.dur = $urandom_range(4);
    else if (pick < 90) w.dur = $urandom_range(20, 5);
    else                w.dur = $urandom();
    w.per = 1'($urandom_range(1));
    return w;
  endfunction

  // offer one word, predict its masks once it is taken
  task automatic send_word(input cmd_word_t w);
    masks_t want;
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= w.cmd;
    in_tdata  <= {3'b000, w.per, w.dur, w.slot};
    do @(posedge clk); while (!in_tready);
    want = next_masks(w.cmd, w.slot, w.dur, w.per);
    expiries += $countones(want.fired);
    cmd_seen[w.cmd]++;
    if (w.has_exp) want = w.exp;
    masks_due.push_back(want);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned held;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_req = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    masks_t got;
    masks_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (masks_due.size() == 0) begin
        $error("result word with no expectation pending: %h", out_tdata);
        mismatches++;
      end else begin
        want = masks_due.pop_front();
        if (got.fired !== want.fired) begin
          $error("fired_mask: expected %h, got %h", want.fired, got.fired);
          mismatches++;
        end
        if (got.active !== want.active) begin
          $error("active_mask: expected %h, got %h", want.active, got.active);
          mismatches++;
        end
        if (got.allocated !== want.allocated) begin
          $error("allocated_mask: expected %h, got %h", want.allocated, got.allocated);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $error("no handshake for %0d cycles, %0d results pending", quiet, masks_due.size());
    $display("tb_multi_channel_soft_timer_table: FAIL");
    $finish;
  end

  // stimulus
  initial begin
    // directed words: expected masks typed in only where obvious
    // reset state, stop and delete on free slots
    directed_words.push_back('{CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b1, {16'h0000, 16'h0000, 16'h0000}});
    directed_words.push_back('{CMD_STOP,   4'd3,  32'd0, 1'b0, 1'b1, {16'h0000, 16'h0000, 16'h0000}});
    directed_words.push_back('{CMD_DELETE, 4'd15, 32'd0, 1'b1, 1'b1, {16'h0000, 16'h0000, 16'h0000}});
    // duration zero one-shot fires on the first tick and is freed
    directed_words.push_back('{CMD_CREATE, 4'd0,  32'd0, 1'b0, 1'b1, {16'h0001, 16'h0001, 16'h0000}});
    directed_words.push_back('{CMD_CREATE, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1,
                               {16'h8001, 16'h8001, 16'h0000}});
    directed_words.push_back('{CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b1, {16'h8000, 16'h8000, 16'h0001}});
    // duration zero periodic fires on every tick
    directed_words.push_back('{CMD_CREATE, 4'd1,  32'd0, 1'b1, 1'b1, {16'h8002, 16'h8002, 16'h0000}});
    directed_words.push_back('{CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b1, {16'h8002, 16'h8002, 16'h0002}});
    // one-shot countdown, stop keeps the slot allocated
    directed_words.push_back('{CMD_CREATE, 4'd2,  32'd2, 1'b0, 1'b0, '0});
    directed_words.push_back('{CMD_STOP,   4'd15, 32'd0, 1'b0, 1'b0, '0});
    directed_words.push_back('{CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, '0});
    directed_words.push_back('{CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, '0});
    // create over an allocated slot reloads it from scratch
    directed_words.push_back('{CMD_CREATE, 4'd1,  32'd1, 1'b0, 1'b0, '0});
    directed_words.push_back('{CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, '0});
    // periodic reload after three ticks
    directed_words.push_back('{CMD_CREATE, 4'd7,  32'd3, 1'b1, 1'b0, '0});
    directed_words.push_back('{CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, '0});
    directed_words.push_back('{CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, '0});
    directed_words.push_back('{CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, '0});
    // stopped slot does not count, then delete frees it
    directed_words.push_back('{CMD_STOP,   4'd7,  32'd0, 1'b0, 1'b0, '0});
    directed_words.push_back('{CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, '0});
    directed_words.push_back('{CMD_DELETE, 4'd15, 32'd0, 1'b0, 1'b0, '0});
    directed_words.push_back('{CMD_DELETE, 4'd7,  32'd0, 1'b0, 1'b0, '0});
    directed_words.push_back('{CMD_CREATE, 4'd10, 32'h8000_0001, 1'b1, 1'b0, '0});
    directed_words.push_back('{CMD_DELETE, 4'd4,  32'hFFFF_FFFF, 1'b1, 1'b0, '0});
    directed_words.push_back('{CMD_TICK,   4'd0,  32'd0, 1'b0, 1'b0, '0});

    // reset
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, no idling
    foreach (directed_words[k]) send_word(directed_words[k]);

    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  hold_req = 1'b1; end
        1: begin in_idle_pct = 68; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 68; end
        default: begin in_idle_pct = 19; out_stall_pct = 19; end
      endcase
      repeat (WORDS_PER_PHASE) send_word(random_word());
    end
    in_tvalid <= 1'b0;

    // drain
    while (masks_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d words (%0d create, %0d stop, %0d delete, %0d tick), %0d expiries",
             cmd_seen[CMD_CREATE] + cmd_seen[CMD_STOP] + cmd_seen[CMD_DELETE] + cmd_seen[CMD_TICK],
             cmd_seen[CMD_CREATE], cmd_seen[CMD_STOP], cmd_seen[CMD_DELETE], cmd_seen[CMD_TICK],
             expiries);
    $display("summary: zero and full-range durations, one-shot and periodic, long output hold-off");
    if (mismatches == 0 && masks_due.size() == 0) begin
      $display("tb_multi_channel_soft_timer_table: PASS");
    end else begin
      $display("tb_multi_channel_soft_timer_table: FAIL");
    end
    $finish;
  end

endmodule
